// ===== hdl/bcd_rtc_with_alarm_and_ram_banks_core_assert.svh =====
// assertion macros shared by the clock core
`ifndef BCD_RTC_WITH_ALARM_AND_RAM_BANKS_CORE_ASSERT_SVH
`define BCD_RTC_WITH_ALARM_AND_RAM_BANKS_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BRTC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("brtc assertion failed");

// next-cycle implication, checked out of reset
`define BRTC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("brtc assertion failed");

`endif

// ===== hdl/brtc_pkg.sv =====
// shared types, constants and helper functions of the bcd clock core
`default_nettype none

package brtc_pkg;

  localparam int unsigned BANK_COUNT = 4;
  localparam int unsigned BANK_REGS  = 13;
  localparam int unsigned BANK_BITS  = $clog2(BANK_COUNT);
  localparam int unsigned RAM_DEPTH  = BANK_COUNT * BANK_REGS;
  localparam int unsigned RAM_AW     = $clog2(RAM_DEPTH);
  localparam int unsigned DIG_COUNT  = 7;

  localparam logic [BANK_BITS-1:0] BANK_TIME  = BANK_BITS'(0);
  localparam logic [BANK_BITS-1:0] BANK_ALARM = BANK_BITS'(1);

  // register offsets
  localparam logic [3:0] OFF_SEC1  = 4'd0;
  localparam logic [3:0] OFF_SEC10 = 4'd1;
  localparam logic [3:0] OFF_MIN1  = 4'd2;
  localparam logic [3:0] OFF_MIN10 = 4'd3;
  localparam logic [3:0] OFF_HR1   = 4'd4;
  localparam logic [3:0] OFF_HR10  = 4'd5;
  localparam logic [3:0] OFF_DOW   = 4'd6;
  localparam logic [3:0] OFF_DAY1  = 4'd7;
  localparam logic [3:0] OFF_DAY10 = 4'd8;
  localparam logic [3:0] OFF_MON1  = 4'd9;
  localparam logic [3:0] OFF_MON10 = 4'd10;
  localparam logic [3:0] OFF_YR1   = 4'd11;
  localparam logic [3:0] OFF_YR10  = 4'd12;
  localparam logic [3:0] OFF_MODE  = 4'd13;
  localparam logic [3:0] OFF_TEST  = 4'd14;
  localparam logic [3:0] OFF_RESET = 4'd15;

  // bit positions in mode and reset registers
  localparam int unsigned MODE_ALARM_BIT = 2;
  localparam int unsigned MODE_TIMER_BIT = 3;
  localparam int unsigned RST_1HZ_BIT    = 0;
  localparam int unsigned RST_16HZ_BIT   = 1;
  localparam int unsigned RST_ALARM_BIT  = 3;

  localparam logic [11:0] LIM_SEC = 12'd59;
  localparam logic [11:0] LIM_MIN = 12'd59;
  localparam logic [11:0] LIM_HR  = 12'd23;
  localparam logic [11:0] LIM_DOW = 12'd6;
  localparam logic [11:0] LIM_MON = 12'd12;
  localparam logic [11:0] LIM_YR  = 12'd99;

  localparam logic [4:0] MONTH_DAYS [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };
  localparam logic [4:0] BAD_MONTH_DAYS = 5'd31;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_TICK1S = 2'd2,
    KIND_TICK16 = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    FLD_SEC,
    FLD_MIN,
    FLD_HR,
    FLD_DOW,
    FLD_DAY,
    FLD_MON,
    FLD_YR
  } field_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EXEC,
    S_RD_WAIT,
    S_SEC_RD,
    S_SEC_UPD,
    S_SEC_TENS,
    S_MIN_UPD,
    S_MIN_TENS,
    S_HR_UPD,
    S_HR_TENS,
    S_MON_PEEK,
    S_DAY_RD,
    S_DAY_UPD,
    S_DAY_TENS,
    S_DOW_UPD,
    S_MON_UPD,
    S_MON_TENS,
    S_YR_UPD,
    S_YR_TENS,
    S_MATCH,
    S_DONE
  } state_e;

  typedef struct packed {
    field_e     field;
    logic [7:0] ones;
    logic [7:0] tens;
    logic       cin;
    logic [4:0] month_len;
  } alu_op_t;

  typedef struct packed {
    logic [11:0] sum;
    logic        carry;
    logic [3:0]  ones;
    logic [3:0]  tens;
  } alu_res_t;

  function automatic logic [RAM_AW-1:0] bank_index(input logic [BANK_BITS-1:0] b,
                                                  input logic [3:0] r);
    return RAM_AW'(b) * RAM_AW'(BANK_REGS) + RAM_AW'(r);
  endfunction

  function automatic logic [4:0] month_len(input logic [11:0] m);
    logic [3:0] i;
    i = m[3:0] - 4'd1;
    if (m >= 12'd1 && m <= LIM_MON) begin
      return MONTH_DAYS[i];
    end
    return BAD_MONTH_DAYS;
  endfunction

  // quotient by ten for values below 128, by reciprocal multiply
  function automatic logic [3:0] div10(input logic [6:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    return p[14:11];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/brtc_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module brtc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 52
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/brtc_alu.sv =====
// shared bcd field unit: pair value, carry in, limit compare, wrap and digit split
`default_nettype none

module brtc_alu import brtc_pkg::*; (
  input  wire alu_op_t op_i,
  output alu_res_t     res_o
);

  logic [11:0] sum;
  logic [11:0] lim;
  logic        wrap_one;
  logic        over;
  logic [6:0]  val;
  logic [3:0]  quo;
  logic [6:0]  quo_x10;

  assign sum = 12'(op_i.tens) * 12'd10 + 12'(op_i.ones) + 12'(op_i.cin);

  always_comb begin
    unique case (op_i.field)
      FLD_SEC: lim = LIM_SEC;
      FLD_MIN: lim = LIM_MIN;
      FLD_HR:  lim = LIM_HR;
      FLD_DOW: lim = LIM_DOW;
      FLD_DAY: lim = 12'(op_i.month_len);
      FLD_MON: lim = LIM_MON;
      FLD_YR:  lim = LIM_YR;
      default: lim = LIM_YR;
    endcase
  end

  // day and month restart at one, the rest at zero
  assign wrap_one = (op_i.field == FLD_DAY) || (op_i.field == FLD_MON);
  assign over     = sum > lim;
  assign val      = over ? {6'd0, wrap_one} : sum[6:0];
  assign quo      = div10(val);
  assign quo_x10  = 7'(quo) * 7'd10;

  assign res_o.sum   = sum;
  assign res_o.carry = over;
  assign res_o.tens  = quo;
  assign res_o.ones  = 4'(val - quo_x10);

endmodule

`default_nettype wire

// ===== hdl/bcd_rtc_with_alarm_and_ram_banks_core.sv =====
// top level of the banked bcd real-time clock with alarm
// Usage:
//   One input channel (in_valid_i / in_stall_o) carries requests: bus read, bus
//   write, one-second tick or sixteenth-second tick, with address_i and
//   write_data_i. Every request gives exactly one response on the output channel
//   (out_valid_o / out_stall_i) with read_data_o and alarm_pulse_o.
//   The block works on one request at a time and stalls its input meanwhile.
//   A bus read of a bank register passes through a ram read-wait state; other
//   reads, bus writes, sixteenth ticks and one-second ticks with the timer off
//   go from the execute state straight to done. An advancing tick walks the
//   time digits through the shared field unit and the ram, then runs the
//   seven-entry alarm compare when the 1 Hz control is off and the mode alarm
//   bit is set. A new request is accepted in the idle state that follows the
//   loading of a response.
//   When the receiver stalls, the response stays in the output register and the
//   next request is accepted and worked on; its response waits until the
//   register is taken.
//   Reset clears all banks (valid bits, no clearing pass), the mode register and
//   the 16 Hz and 1 Hz controls, and enables the seconds timer.
`default_nettype none

module bcd_rtc_with_alarm_and_ram_banks_core import brtc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] kind_i,
  input  wire logic [3:0] address_i,
  input  wire logic [7:0] write_data_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic      [7:0] read_data_o,
  output logic            alarm_pulse_o
);

`include "bcd_rtc_with_alarm_and_ram_banks_core_assert.svh"

  state_e state_q, state_d;

  kind_e       kind_q;
  logic [3:0]  addr_q;
  logic [7:0]  data_q;
  logic [7:0]  mode_q;
  logic        timer_on_q;
  logic        sixteen_on_q;
  logic        one_hz_off_q;
  logic [RAM_DEPTH-1:0] valid_q;
  logic        rd_vld_q;
  logic [7:0]  ones_q;
  logic [3:0]  tens_wr_q;
  logic        carry_q;
  logic        hr_carry_q;
  logic [4:0]  len_q;
  logic [7:0]  mon_ones_q;
  logic [7:0]  mon_tens_q;
  logic [3:0]  dig_q [DIG_COUNT];
  logic        match_q;
  logic [2:0]  cnt_q;
  logic [7:0]  res_data_q;
  logic        res_pulse_q;
  logic        out_valid_q;
  logic [7:0]  out_data_q;
  logic        out_pulse_q;

  logic              in_accept;
  logic              out_free;
  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [RAM_AW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  logic [7:0]        rd_data;
  logic [RAM_AW-1:0] bus_idx;
  logic              clr_alarm;
  logic [2:0]        dig_sel;
  logic              match_now;
  alu_op_t           alu_op;
  alu_res_t          alu_res;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign bus_idx   = (addr_q < OFF_MODE) ? bank_index(mode_q[BANK_BITS-1:0], addr_q) : '0;
  assign rd_data   = rd_vld_q ? ram_rdata : 8'd0;
  assign clr_alarm = (state_q == S_EXEC) && (kind_q == KIND_WRITE) &&
                     (addr_q == OFF_RESET) && data_q[RST_ALARM_BIT];

  // alarm compare walks offsets 2..8, data arrives in the cycle after its address
  assign dig_sel   = (cnt_q == 3'd0) ? 3'd0 : cnt_q - 3'd1;
  assign match_now = match_q && ((cnt_q == 3'd0) || (rd_data == {4'd0, dig_q[dig_sel]}));

  brtc_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  brtc_alu u_alu (
    .op_i  (alu_op),
    .res_o (alu_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        unique case (kind_q)
          KIND_READ:   state_d = (addr_q < OFF_MODE) ? S_RD_WAIT : S_DONE;
          KIND_WRITE:  state_d = S_DONE;
          KIND_TICK1S: state_d = timer_on_q ? S_SEC_RD : S_DONE;
          KIND_TICK16: state_d = S_DONE;
        endcase
      end
      S_RD_WAIT:  state_d = S_DONE;
      S_SEC_RD:   state_d = S_SEC_UPD;
      S_SEC_UPD:  state_d = S_SEC_TENS;
      S_SEC_TENS: state_d = S_MIN_UPD;
      S_MIN_UPD:  state_d = S_MIN_TENS;
      S_MIN_TENS: state_d = S_HR_UPD;
      S_HR_UPD:   state_d = S_HR_TENS;
      S_HR_TENS:  state_d = S_MON_PEEK;
      S_MON_PEEK: state_d = S_DAY_RD;
      S_DAY_RD:   state_d = S_DAY_UPD;
      S_DAY_UPD:  state_d = S_DAY_TENS;
      S_DAY_TENS: state_d = S_DOW_UPD;
      S_DOW_UPD:  state_d = S_MON_UPD;
      S_MON_UPD:  state_d = S_MON_TENS;
      S_MON_TENS: state_d = S_YR_UPD;
      S_YR_UPD:   state_d = S_YR_TENS;
      S_YR_TENS: begin
        if (one_hz_off_q && mode_q[MODE_ALARM_BIT]) state_d = S_MATCH;
        else state_d = S_DONE;
      end
      S_MATCH: begin
        if (cnt_q == 3'd7) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ram and field unit controls
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = 8'd0;
    ram_raddr = '0;
    alu_op    = '0;
    unique case (state_q)
      S_EXEC: begin
        ram_raddr = (kind_q == KIND_TICK1S) ? bank_index(BANK_TIME, OFF_SEC1) : bus_idx;
        if (kind_q == KIND_WRITE && addr_q < OFF_MODE) begin
          ram_we    = 1'b1;
          ram_waddr = bus_idx;
          ram_wdata = data_q;
        end
      end
      S_SEC_RD: ram_raddr = bank_index(BANK_TIME, OFF_SEC10);
      S_SEC_UPD: begin
        alu_op.field = FLD_SEC;
        alu_op.ones  = ones_q;
        alu_op.tens  = rd_data;
        alu_op.cin   = 1'b1;
        ram_we       = 1'b1;
        ram_waddr    = bank_index(BANK_TIME, OFF_SEC1);
        ram_wdata    = {4'd0, alu_res.ones};
        ram_raddr    = bank_index(BANK_TIME, OFF_MIN1);
      end
      S_SEC_TENS: begin
        ram_we    = 1'b1;
        ram_waddr = bank_index(BANK_TIME, OFF_SEC10);
        ram_wdata = {4'd0, tens_wr_q};
        ram_raddr = bank_index(BANK_TIME, OFF_MIN10);
      end
      S_MIN_UPD: begin
        alu_op.field = FLD_MIN;
        alu_op.ones  = ones_q;
        alu_op.tens  = rd_data;
        alu_op.cin   = carry_q;
        ram_we       = 1'b1;
        ram_waddr    = bank_index(BANK_TIME, OFF_MIN1);
        ram_wdata    = {4'd0, alu_res.ones};
        ram_raddr    = bank_index(BANK_TIME, OFF_HR1);
      end
      S_MIN_TENS: begin
        ram_we    = 1'b1;
        ram_waddr = bank_index(BANK_TIME, OFF_MIN10);
        ram_wdata = {4'd0, tens_wr_q};
        ram_raddr = bank_index(BANK_TIME, OFF_HR10);
      end
      S_HR_UPD: begin
        alu_op.field = FLD_HR;
        alu_op.ones  = ones_q;
        alu_op.tens  = rd_data;
        alu_op.cin   = carry_q;
        ram_we       = 1'b1;
        ram_waddr    = bank_index(BANK_TIME, OFF_HR1);
        ram_wdata    = {4'd0, alu_res.ones};
        ram_raddr    = bank_index(BANK_TIME, OFF_MON1);
      end
      S_HR_TENS: begin
        ram_we    = 1'b1;
        ram_waddr = bank_index(BANK_TIME, OFF_HR10);
        ram_wdata = {4'd0, tens_wr_q};
        ram_raddr = bank_index(BANK_TIME, OFF_MON10);
      end
      S_MON_PEEK: begin
        // raw month value only, to pick the day limit
        alu_op.field = FLD_MON;
        alu_op.ones  = ones_q;
        alu_op.tens  = rd_data;
        ram_raddr    = bank_index(BANK_TIME, OFF_DAY1);
      end
      S_DAY_RD: ram_raddr = bank_index(BANK_TIME, OFF_DAY10);
      S_DAY_UPD: begin
        alu_op.field     = FLD_DAY;
        alu_op.ones      = ones_q;
        alu_op.tens      = rd_data;
        alu_op.cin       = hr_carry_q;
        alu_op.month_len = len_q;
        ram_we           = 1'b1;
        ram_waddr        = bank_index(BANK_TIME, OFF_DAY1);
        ram_wdata        = {4'd0, alu_res.ones};
        ram_raddr        = bank_index(BANK_TIME, OFF_DOW);
      end
      S_DAY_TENS: begin
        ram_we    = 1'b1;
        ram_waddr = bank_index(BANK_TIME, OFF_DAY10);
        ram_wdata = {4'd0, tens_wr_q};
      end
      S_DOW_UPD: begin
        alu_op.field = FLD_DOW;
        alu_op.ones  = ones_q;
        alu_op.cin   = hr_carry_q;
        ram_we       = 1'b1;
        ram_waddr    = bank_index(BANK_TIME, OFF_DOW);
        ram_wdata    = {4'd0, alu_res.ones};
      end
      S_MON_UPD: begin
        alu_op.field = FLD_MON;
        alu_op.ones  = mon_ones_q;
        alu_op.tens  = mon_tens_q;
        alu_op.cin   = carry_q;
        ram_we       = 1'b1;
        ram_waddr    = bank_index(BANK_TIME, OFF_MON1);
        ram_wdata    = {4'd0, alu_res.ones};
        ram_raddr    = bank_index(BANK_TIME, OFF_YR1);
      end
      S_MON_TENS: begin
        ram_we    = 1'b1;
        ram_waddr = bank_index(BANK_TIME, OFF_MON10);
        ram_wdata = {4'd0, tens_wr_q};
        ram_raddr = bank_index(BANK_TIME, OFF_YR10);
      end
      S_YR_UPD: begin
        alu_op.field = FLD_YR;
        alu_op.ones  = ones_q;
        alu_op.tens  = rd_data;
        alu_op.cin   = carry_q;
        ram_we       = 1'b1;
        ram_waddr    = bank_index(BANK_TIME, OFF_YR1);
        ram_wdata    = {4'd0, alu_res.ones};
      end
      S_YR_TENS: begin
        ram_we    = 1'b1;
        ram_waddr = bank_index(BANK_TIME, OFF_YR10);
        ram_wdata = {4'd0, tens_wr_q};
      end
      S_MATCH: ram_raddr = bank_index(BANK_ALARM, OFF_MIN1 + 4'(cnt_q));
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      mode_q       <= 8'd0;
      timer_on_q   <= 1'b1;
      sixteen_on_q <= 1'b0;
      one_hz_off_q <= 1'b0;
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
      cnt_q        <= 3'd0;
    end else begin
      state_q <= state_d;
      if (state_q == S_EXEC && kind_q == KIND_WRITE) begin
        if (addr_q == OFF_MODE) begin
          mode_q     <= data_q;
          timer_on_q <= data_q[MODE_TIMER_BIT];
        end else if (addr_q == OFF_RESET) begin
          sixteen_on_q <= !data_q[RST_16HZ_BIT];
          one_hz_off_q <= data_q[RST_1HZ_BIT];
        end
      end
      if (ram_we) valid_q[ram_waddr] <= 1'b1;
      // clearing the alarm digits drops their valid bits, so they read as zero
      if (clr_alarm) begin
        for (int i = OFF_MIN1; i <= OFF_DAY10; i++) begin
          valid_q[bank_index(BANK_ALARM, 4'(i))] <= 1'b0;
        end
      end
      if (state_q == S_YR_TENS) cnt_q <= 3'd0;
      else if (state_q == S_MATCH) cnt_q <= cnt_q + 3'd1;
      if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rd_vld_q <= valid_q[ram_raddr];
    if (in_accept) begin
      kind_q <= kind_e'(kind_i);
      addr_q <= address_i;
      data_q <= write_data_i;
    end
    unique case (state_q)
      S_EXEC: begin
        res_data_q  <= (kind_q == KIND_READ && addr_q == OFF_MODE) ? mode_q : 8'd0;
        res_pulse_q <= (kind_q == KIND_TICK16) && sixteen_on_q;
      end
      S_RD_WAIT: res_data_q <= rd_data;
      S_SEC_RD, S_SEC_TENS, S_MIN_TENS, S_DAY_TENS, S_MON_TENS: ones_q <= rd_data;
      S_HR_TENS: ones_q <= rd_data;
      S_SEC_UPD: begin
        tens_wr_q <= alu_res.tens;
        carry_q   <= alu_res.carry;
      end
      S_MIN_UPD: begin
        tens_wr_q <= alu_res.tens;
        carry_q   <= alu_res.carry;
        dig_q[0]  <= alu_res.ones;
        dig_q[1]  <= alu_res.tens;
      end
      S_HR_UPD: begin
        tens_wr_q  <= alu_res.tens;
        hr_carry_q <= alu_res.carry;
        dig_q[2]   <= alu_res.ones;
        dig_q[3]   <= alu_res.tens;
      end
      S_MON_PEEK: begin
        len_q      <= month_len(alu_res.sum);
        mon_ones_q <= ones_q;
        mon_tens_q <= rd_data;
      end
      S_DAY_RD: ones_q <= rd_data;
      S_DAY_UPD: begin
        tens_wr_q <= alu_res.tens;
        carry_q   <= alu_res.carry;
        dig_q[5]  <= alu_res.ones;
        dig_q[6]  <= alu_res.tens;
      end
      S_DOW_UPD: dig_q[4] <= alu_res.ones;
      S_MON_UPD: begin
        tens_wr_q <= alu_res.tens;
        carry_q   <= alu_res.carry;
      end
      S_YR_UPD: tens_wr_q <= alu_res.tens;
      S_YR_TENS: begin
        match_q     <= 1'b1;
        res_pulse_q <= !one_hz_off_q;
      end
      S_MATCH: begin
        match_q <= match_now;
        if (cnt_q == 3'd7) res_pulse_q <= match_now;
      end
      default: begin
      end
    endcase
    if (state_q == S_DONE && out_free) begin
      out_data_q  <= res_data_q;
      out_pulse_q <= res_pulse_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = out_data_q;
  assign alarm_pulse_o = out_pulse_q;

  `BRTC_ASSERT_NEXT(a_accept_starts, in_valid_i && !in_stall_o, state_q == S_EXEC)
  `BRTC_ASSERT_NOW(a_no_write_idle,
    state_q == S_IDLE || state_q == S_DONE || state_q == S_MATCH, !ram_we)
  `BRTC_ASSERT_NOW(a_bus_no_pulse,
    state_q == S_DONE && (kind_q == KIND_READ || kind_q == KIND_WRITE), !res_pulse_q)
  `BRTC_ASSERT_NOW(a_tick_no_data, state_q == S_DONE && kind_q != KIND_READ,
    res_data_q == 8'd0)
  `BRTC_ASSERT_NEXT(a_done_holds, state_q == S_DONE && out_valid_q && out_stall_i,
    state_q == S_DONE)

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the banked bcd clock core: directed table then random traffic
module tb_top;
  import brtc_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [7:0] rd;
    logic       pulse;
  } resp_t;

  typedef struct packed {
    kind_e      kind;
    logic [3:0] addr;
    logic [7:0] data;
    logic       typed;
    resp_t      resp;
  } stim_row_t;

  // rows with typed=0 are checked against the predictor only
  localparam stim_row_t DIRECTED [26] = '{
    '{KIND_READ,   OFF_SEC1,  8'h00, 1'b1, '{8'h00, 1'b0}},
    '{KIND_READ,   OFF_MODE,  8'h00, 1'b1, '{8'h00, 1'b0}},
    '{KIND_TICK1S, OFF_SEC1,  8'h00, 1'b1, '{8'h00, 1'b1}},
    '{KIND_READ,   OFF_SEC1,  8'h00, 1'b1, '{8'h01, 1'b0}},
    '{KIND_WRITE,  OFF_RESET, 8'h00, 1'b1, '{8'h00, 1'b0}},
    '{KIND_TICK16, OFF_RESET, 8'hff, 1'b1, '{8'h00, 1'b1}},
    '{KIND_WRITE,  OFF_TEST,  8'hff, 1'b1, '{8'h00, 1'b0}},
    // 23:59:59 on day 31 of the bad month zero, weekday 6
    '{KIND_WRITE,  OFF_SEC1,  8'h09, 1'b1, '{8'h00, 1'b0}},
    '{KIND_WRITE,  OFF_SEC10, 8'h05, 1'b1, '{8'h00, 1'b0}},
    '{KIND_WRITE,  OFF_MIN1,  8'h09, 1'b1, '{8'h00, 1'b0}},
    '{KIND_WRITE,  OFF_MIN10, 8'h05, 1'b1, '{8'h00, 1'b0}},
    '{KIND_WRITE,  OFF_HR1,   8'h03, 1'b1, '{8'h00, 1'b0}},
    '{KIND_WRITE,  OFF_HR10,  8'h02, 1'b1, '{8'h00, 1'b0}},
    '{KIND_WRITE,  OFF_DOW,   8'h06, 1'b1, '{8'h00, 1'b0}},
    '{KIND_WRITE,  OFF_DAY1,  8'h01, 1'b1, '{8'h00, 1'b0}},
    '{KIND_WRITE,  OFF_DAY10, 8'h03, 1'b1, '{8'h00, 1'b0}},
    '{KIND_TICK1S, OFF_YR10,  8'hff, 1'b1, '{8'h00, 1'b1}},
    '{KIND_READ,   OFF_MON1,  8'h00, 1'b0, '{8'h00, 1'b0}},
    '{KIND_READ,   OFF_DOW,   8'h00, 1'b0, '{8'h00, 1'b0}},
    '{KIND_WRITE,  OFF_MODE,  8'h00, 1'b1, '{8'h00, 1'b0}},
    '{KIND_TICK1S, OFF_SEC1,  8'h00, 1'b1, '{8'h00, 1'b0}},
    '{KIND_WRITE,  OFF_RESET, 8'hff, 1'b1, '{8'h00, 1'b0}},
    '{KIND_TICK16, OFF_SEC1,  8'h00, 1'b1, '{8'h00, 1'b0}},
    '{KIND_WRITE,  OFF_MODE,  8'hff, 1'b1, '{8'h00, 1'b0}},
    '{KIND_READ,   OFF_MODE,  8'h00, 1'b1, '{8'hff, 1'b0}},
    '{KIND_READ,   OFF_YR10,  8'h00, 1'b0, '{8'h00, 1'b0}}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] kind_i;
  logic [3:0] address_i;
  logic [7:0] write_data_i;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] read_data_o;
  logic       alarm_pulse_o;

  // predictor state
  logic [7:0]  rtc_regs [RAM_DEPTH];
  logic [7:0]  rtc_mode;
  logic        timer_on;
  logic        sixteen_on;
  logic        one_hz_off;

  resp_t       pending_resp [$];
  int unsigned sent        = 0;
  int unsigned bad_count   = 0;
  int unsigned cycle_count = 0;
  logic        calm        = 1'b0;

  bcd_rtc_with_alarm_and_ram_banks_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .address_i     (address_i),
    .write_data_i  (write_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_data_o   (read_data_o),
    .alarm_pulse_o (alarm_pulse_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned time_pair(input int unsigned ones);
    return int'(rtc_regs[ones + 1]) * 10 + int'(rtc_regs[ones]);
  endfunction

  function automatic void put_time_pair(input int unsigned ones, input int unsigned v);
    rtc_regs[ones]     = 8'(v % 10);
    rtc_regs[ones + 1] = 8'(v / 10);
  endfunction

  function automatic void advance_clock();
    int unsigned sec, mn, hr, dow, day, mon, yr, len;
    sec = time_pair(OFF_SEC1) + 1;
    mn  = time_pair(OFF_MIN1);
    hr  = time_pair(OFF_HR1);
    dow = rtc_regs[OFF_DOW];
    day = time_pair(OFF_DAY1);
    mon = time_pair(OFF_MON1);
    yr  = time_pair(OFF_YR1);
    if (sec > LIM_SEC) begin
      sec = 0;
      mn++;
    end
    if (mn > LIM_MIN) begin
      mn = 0;
      hr++;
    end
    if (hr > LIM_HR) begin
      hr = 0;
      day++;
      dow++;
    end
    if (dow > LIM_DOW) dow = 0;
    // out-of-range months count 31 days, february never has 29
    len = (mon >= 1 && mon <= LIM_MON) ? MONTH_DAYS[mon - 1] : BAD_MONTH_DAYS;
    if (day > len) begin
      day = 1;
      mon++;
    end
    if (mon > LIM_MON) begin
      mon = 1;
      yr++;
    end
    if (yr > LIM_YR) yr = 0;
    put_time_pair(OFF_SEC1, sec);
    put_time_pair(OFF_MIN1, mn);
    put_time_pair(OFF_HR1, hr);
    rtc_regs[OFF_DOW] = 8'(dow);
    put_time_pair(OFF_DAY1, day);
    put_time_pair(OFF_MON1, mon);
    put_time_pair(OFF_YR1, yr);
  endfunction

  function automatic logic alarm_hit();
    for (int i = OFF_MIN1; i <= OFF_DAY10; i++) begin
      if (rtc_regs[BANK_REGS + i] != rtc_regs[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic resp_t clock_step(input kind_e k, input logic [3:0] a,
                                       input logic [7:0] d);
    resp_t       r;
    int unsigned bank;
    r    = '0;
    bank = rtc_mode[BANK_BITS-1:0];
    case (k)
      KIND_READ: begin
        if (a == OFF_MODE) r.rd = rtc_mode;
        else if (a == OFF_TEST || a == OFF_RESET) r.rd = 8'h00;
        else r.rd = rtc_regs[bank * BANK_REGS + a];
      end
      KIND_WRITE: begin
        if (a == OFF_MODE) begin
          rtc_mode = d;
          timer_on = d[MODE_TIMER_BIT];
        end else if (a == OFF_RESET) begin
          if (d[RST_ALARM_BIT]) begin
            for (int i = OFF_MIN1; i <= OFF_DAY10; i++) rtc_regs[BANK_REGS + i] = 8'h00;
          end
          sixteen_on = !d[RST_16HZ_BIT];
          one_hz_off = d[RST_1HZ_BIT];
        end else if (a != OFF_TEST) begin
          rtc_regs[bank * BANK_REGS + a] = d;
        end
      end
      KIND_TICK1S: begin
        if (timer_on) begin
          advance_clock();
          r.pulse = !one_hz_off || (rtc_mode[MODE_ALARM_BIT] && alarm_hit());
        end
      end
      default: r.pulse = sixteen_on;
    endcase
    return r;
  endfunction

  task automatic send(input kind_e k, input logic [3:0] a, input logic [7:0] d,
                      input logic typed = 1'b0, input resp_t typed_resp = '0);
    resp_t got;
    while (!calm && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= k;
    address_i    <= a;
    write_data_i <= d;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    got = clock_step(k, a, d);
    pending_resp.push_back(typed ? typed_resp : got);
    // test-register writes do nothing and are not counted
    if (!(k == KIND_WRITE && a == OFF_TEST)) sent++;
    calm = (sent >= 350 && sent < 550);
  endtask

  task automatic log_bad(input string msg);
    bad_count++;
    if (bad_count <= 10) $display("%0t response error: %s", $time, msg);
  endtask

  always @(posedge clk_i) begin
    resp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_resp.size() == 0) begin
        log_bad($sformatf("unexpected rd=%02h pulse=%0b", read_data_o, alarm_pulse_o));
      end else begin
        want = pending_resp.pop_front();
        if (want.rd !== read_data_o || want.pulse !== alarm_pulse_o)
          log_bad($sformatf("expected rd=%02h pulse=%0b, got rd=%02h pulse=%0b",
                            want.rd, want.pulse, read_data_o, alarm_pulse_o));
      end
    end
  end

  always @(posedge clk_i) out_stall_i <= !calm && ($urandom_range(99) < 6);

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bcd_rtc_with_alarm_and_ram_banks_core: mismatch");
      $finish;
    end
  end

  initial begin
    int unsigned sec, mn, hr, dow, day, mon, yr, len;
    logic [7:0]  dig [13];
    logic [7:0]  mode_byte;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    kind_i       <= KIND_READ;
    address_i    <= '0;
    write_data_i <= '0;
    foreach (rtc_regs[i]) rtc_regs[i] = 8'h00;
    rtc_mode   = 8'h00;
    timer_on   = 1'b1;
    sixteen_on = 1'b0;
    one_hz_off = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED[i])
      send(DIRECTED[i].kind, DIRECTED[i].addr, DIRECTED[i].data, DIRECTED[i].typed,
           DIRECTED[i].resp);

    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(9))
        0, 1: begin
          // load a time close to a rollover, then tick through it
          mode_byte = {4'($urandom), 1'b1, 1'($urandom), 2'd0};
          send(KIND_WRITE, OFF_MODE, mode_byte);
          sec = ($urandom_range(3) == 0) ? $urandom_range(59) : $urandom_range(59, 57);
          mn  = $urandom_range(1) ? 59 : $urandom_range(59);
          hr  = $urandom_range(1) ? 23 : $urandom_range(23);
          dow = $urandom_range(7);
          mon = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(12, 1);
          len = (mon >= 1 && mon <= LIM_MON) ? MONTH_DAYS[mon - 1] : BAD_MONTH_DAYS;
          day = $urandom_range(1) ? len : $urandom_range(len, 1);
          yr  = $urandom_range(1) ? 99 : $urandom_range(99);
          dig = '{8'(sec % 10), 8'(sec / 10), 8'(mn % 10), 8'(mn / 10),
                  8'(hr % 10), 8'(hr / 10), 8'(dow), 8'(day % 10), 8'(day / 10),
                  8'(mon % 10), 8'(mon / 10), 8'(yr % 10), 8'(yr / 10)};
          if ($urandom_range(5) == 0) dig[$urandom_range(12)] = 8'($urandom);
          for (int i = 0; i < 13; i++) send(KIND_WRITE, 4'(i), dig[i]);
          repeat ($urandom_range(3, 1)) send(KIND_TICK1S, 4'($urandom), 8'($urandom));
          send(KIND_READ, 4'($urandom_range(12)), 8'($urandom));
        end
        2, 3: begin
          // copy the time digits into the alarm bank and run with 1 hz off
          send(KIND_WRITE, OFF_MODE, {4'($urandom), 1'b1, 1'b1, 2'd1});
          for (int i = OFF_MIN1; i <= OFF_DAY10; i++)
            send(KIND_WRITE, 4'(i), ($urandom_range(7) == 0) ? 8'($urandom) : rtc_regs[i]);
          send(KIND_WRITE, OFF_RESET, {4'($urandom), ($urandom_range(4) == 0),
                                       1'($urandom), 1'($urandom), 1'b1});
          send(KIND_WRITE, OFF_MODE, {4'($urandom), 1'b1, ($urandom_range(5) != 0), 2'd0});
          repeat ($urandom_range(4, 1)) send(KIND_TICK1S, 4'($urandom), 8'($urandom));
          send(KIND_TICK16, 4'($urandom), 8'($urandom));
        end
        4: begin
          repeat ($urandom_range(6, 1))
            send($urandom_range(1) ? KIND_TICK1S : KIND_TICK16, 4'($urandom), 8'($urandom));
        end
        5: begin
          // ram banks
          send(KIND_WRITE, OFF_MODE, {4'($urandom), 1'($urandom), 1'($urandom),
                                      2'($urandom_range(3, 2))});
          repeat ($urandom_range(6, 2)) begin
            if ($urandom_range(1)) send(KIND_WRITE, 4'($urandom_range(12)), 8'($urandom));
            else send(KIND_READ, 4'($urandom), 8'($urandom));
          end
        end
        6: send(KIND_WRITE, OFF_RESET, 8'($urandom));
        7: begin
          repeat ($urandom_range(4, 1))
            send(kind_e'(2'($urandom)), 4'($urandom), 8'($urandom));
        end
        8: begin
          repeat ($urandom_range(4, 1)) send(KIND_READ, 4'($urandom), 8'($urandom));
        end
        default: begin
          // seconds timer stopped
          send(KIND_WRITE, OFF_MODE, {4'($urandom), 1'b0, 1'($urandom), 2'($urandom)});
          send(KIND_TICK1S, 4'($urandom), 8'($urandom));
          send(KIND_READ, OFF_SEC1, 8'($urandom));
          send(KIND_WRITE, OFF_MODE, {4'($urandom), 1'b1, 1'($urandom), 2'd0});
        end
      endcase
    end

    in_valid_i <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (bad_count == 0) begin
      $display("bcd_rtc_with_alarm_and_ram_banks_core: match");
    end else begin
      $display("bcd_rtc_with_alarm_and_ram_banks_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/brtc_pkg.sv
hdl/brtc_ram.sv
hdl/brtc_alu.sv
hdl/bcd_rtc_with_alarm_and_ram_banks_core.sv
sim/tb_top.sv
